// ===== rtl/stb_pkg.sv =====
// Shared types and constants for the timer bank.
// No dependencies; used by stb_ctrl, stb_datapath and software_timer_bank_core.
package stb_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int OP_W       = 3;
  localparam int TIDX_W     = 4;
  localparam int TIME_W     = 32;
  localparam int CELL_W     = 16;
  localparam int STAT_W     = 2;
  localparam int SLOT_W     = 4;

  typedef logic [IDX_W-1:0] idx_t;

  localparam idx_t LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 3'd0,
    OP_OPEN  = 3'd1,
    OP_CLOSE = 3'd2,
    OP_STOP  = 3'd3,
    OP_START = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    RS_OK    = 2'd0,
    RS_BAD   = 2'd1,
    RS_FULL  = 2'd2,
    RS_UNSUP = 2'd3
  } rsp_t;

  typedef enum logic [1:0] {
    SL_CLOSED  = 2'd0,
    SL_OPEN    = 2'd1,
    SL_STOPPED = 2'd2,
    SL_STARTED = 2'd3
  } slot_st_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic start;   // item accepted this cycle
    logic scan;    // evaluating one slot of a tick scan
    logic flush;   // emit the held expiry as the final one
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic is_tick;
    logic advance;
    logic pend_valid;
    logic last_idx;
  } dp_stat_t;

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] timeout;
    logic              rpt;
    logic [CELL_W-1:0] cval;
  } slot_rec_t;

endpackage

// ===== rtl/stb_ctrl.sv =====
// Sequencer for the timer bank: idle / tick scan / final flush.
// Depends on stb_pkg.
module stb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  stb_pkg::dp_stat_t stat,
  output logic              in_ready,
  output stb_pkg::ctl_cmd_t cmd
);

  stb_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      stb_pkg::ST_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          cmd.start = 1'b1;
          if (stat.is_tick) begin
            state_next = stb_pkg::ST_SCAN;
          end
        end
      end
      stb_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.advance && stat.last_idx) begin
          state_next = stb_pkg::ST_FLUSH;
        end
      end
      stb_pkg::ST_FLUSH: begin
        if (!stat.pend_valid) begin
          state_next = stb_pkg::ST_IDLE;
        end else if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = stb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = stb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/stb_datapath.sv =====
// Timer bank datapath: tick counter, slot states, slot record memory,
// held expiry and output register. Depends on stb_pkg.
module stb_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [stb_pkg::OP_W-1:0]     operation,
  input  logic [stb_pkg::TIDX_W-1:0]   timer_index,
  input  logic [stb_pkg::TIME_W-1:0]   timeout_ticks,
  input  logic                         repeat_flag,
  input  logic [stb_pkg::CELL_W-1:0]   soft_cell,
  input  logic                         out_ready,
  input  stb_pkg::ctl_cmd_t            cmd,
  output stb_pkg::dp_stat_t            stat,
  output logic                         out_valid,
  output logic                         kind,
  output logic [stb_pkg::STAT_W-1:0]   status,
  output logic [stb_pkg::SLOT_W-1:0]   slot,
  output logic [stb_pkg::CELL_W-1:0]   cell_value,
  output logic                         last
);

  stb_pkg::op_t      op;
  logic [stb_pkg::TIME_W-1:0] now_ticks;
  stb_pkg::slot_st_t slot_status [stb_pkg::NUM_TIMERS];
  stb_pkg::slot_rec_t rec_mem    [stb_pkg::NUM_TIMERS];
  stb_pkg::slot_rec_t rd_rec;
  stb_pkg::slot_rec_t mem_wdata;
  stb_pkg::idx_t     mem_waddr, mem_raddr;
  logic              mem_we, mem_re;
  stb_pkg::idx_t     eval_idx;
  stb_pkg::idx_t     free_idx, tgt_idx;
  logic              free_found, idx_oob, tgt_bad;
  logic              cur_live, expired, out_free, advance, do_adv;
  logic [stb_pkg::TIME_W-1:0] elapsed;
  logic              pend_valid;
  logic [stb_pkg::SLOT_W-1:0] pend_slot;
  logic [stb_pkg::CELL_W-1:0] pend_cell;
  stb_pkg::rsp_t     rsp;
  logic [stb_pkg::SLOT_W-1:0] rsp_slot;
  logic              out_load, reply_load, emit_mid;
  logic              kind_next, last_next;
  logic [stb_pkg::STAT_W-1:0] status_next;
  logic [stb_pkg::SLOT_W-1:0] slot_next;
  logic [stb_pkg::CELL_W-1:0] cell_next;

  assign op = stb_pkg::op_t'(operation);

  // lowest closed slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = stb_pkg::NUM_TIMERS - 1; i >= 0; i--) begin
      if (slot_status[i] == stb_pkg::SL_CLOSED) begin
        free_found = 1'b1;
        free_idx   = stb_pkg::IDX_W'(i);
      end
    end
  end

  assign idx_oob = (int'(timer_index) >= stb_pkg::NUM_TIMERS);
  assign tgt_idx = stb_pkg::IDX_W'(timer_index);
  assign tgt_bad = idx_oob ? 1'b1 : (slot_status[tgt_idx] == stb_pkg::SL_CLOSED);

  // reply to a non-tick operation
  always_comb begin
    rsp      = stb_pkg::RS_OK;
    rsp_slot = '0;
    case (op) inside
      stb_pkg::OP_TICK: begin
        rsp = stb_pkg::RS_OK;
      end
      stb_pkg::OP_OPEN: begin
        rsp      = free_found ? stb_pkg::RS_OK : stb_pkg::RS_FULL;
        rsp_slot = free_found ? stb_pkg::SLOT_W'(free_idx) : '0;
      end
      stb_pkg::OP_CLOSE, stb_pkg::OP_STOP, stb_pkg::OP_START: begin
        rsp = tgt_bad ? stb_pkg::RS_BAD : stb_pkg::RS_OK;
      end
      default: begin
        rsp = stb_pkg::RS_UNSUP;
      end
    endcase
  end

  // scan evaluation of the slot whose record sits in rd_rec
  assign cur_live = (slot_status[eval_idx] == stb_pkg::SL_OPEN) ||
                    (slot_status[eval_idx] == stb_pkg::SL_STARTED);
  assign elapsed  = now_ticks - rd_rec.start;
  assign expired  = cur_live && (elapsed >= rd_rec.timeout);
  assign out_free = !out_valid || out_ready;
  // a new expiry with one already held needs the output register
  assign advance  = !(expired && pend_valid && !out_free);
  assign do_adv   = cmd.scan && advance;
  assign emit_mid = do_adv && expired && pend_valid;

  assign stat.out_free   = out_free;
  assign stat.is_tick    = (op == stb_pkg::OP_TICK);
  assign stat.advance    = advance;
  assign stat.pend_valid = pend_valid;
  assign stat.last_idx   = (eval_idx == stb_pkg::LAST_IDX);

  // record memory: one write, one registered read per cycle
  assign mem_we    = (cmd.start && op == stb_pkg::OP_OPEN && free_found) ||
                     (do_adv && expired);
  assign mem_waddr = cmd.start ? free_idx : eval_idx;
  assign mem_wdata = cmd.start ?
                     stb_pkg::slot_rec_t'{start: now_ticks, timeout: timeout_ticks,
                                          rpt: repeat_flag, cval: soft_cell} :
                     stb_pkg::slot_rec_t'{start: now_ticks, timeout: rd_rec.timeout,
                                          rpt: rd_rec.rpt, cval: rd_rec.cval};
  assign mem_re    = (cmd.start && op == stb_pkg::OP_TICK) ||
                     (do_adv && eval_idx != stb_pkg::LAST_IDX);
  assign mem_raddr = cmd.start ? '0 : stb_pkg::IDX_W'(eval_idx + 1'b1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rec_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_rec <= rec_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ticks <= '0;
      eval_idx  <= '0;
    end else begin
      if (cmd.start && op == stb_pkg::OP_TICK) begin
        now_ticks <= now_ticks + 1'b1;
      end
      if (cmd.start) begin
        eval_idx <= '0;
      end else if (do_adv) begin
        eval_idx <= (eval_idx == stb_pkg::LAST_IDX) ? '0 : stb_pkg::IDX_W'(eval_idx + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < stb_pkg::NUM_TIMERS; i++) begin
        slot_status[i] <= stb_pkg::SL_CLOSED;
      end
    end else begin
      if (cmd.start) begin
        unique case (op) inside
          stb_pkg::OP_OPEN: begin
            if (free_found) slot_status[free_idx] <= stb_pkg::SL_OPEN;
          end
          stb_pkg::OP_CLOSE: begin
            if (!tgt_bad) slot_status[tgt_idx] <= stb_pkg::SL_CLOSED;
          end
          stb_pkg::OP_STOP: begin
            if (!tgt_bad) slot_status[tgt_idx] <= stb_pkg::SL_STOPPED;
          end
          stb_pkg::OP_START: begin
            if (!tgt_bad) slot_status[tgt_idx] <= stb_pkg::SL_STARTED;
          end
          default: begin
          end
        endcase
      end
      if (do_adv && expired && !rd_rec.rpt) begin
        slot_status[eval_idx] <= stb_pkg::SL_STOPPED;
      end
    end
  end

  // held expiry: sent once the next one (or the end of scan) is known
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.start || cmd.flush) begin
      pend_valid <= 1'b0;
    end else if (do_adv && expired) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_adv && expired) begin
      pend_slot <= stb_pkg::SLOT_W'(eval_idx);
      pend_cell <= rd_rec.cval;
    end
  end

  // output register
  assign reply_load = cmd.start && op != stb_pkg::OP_TICK;
  assign out_load   = reply_load || emit_mid || cmd.flush;

  always_comb begin
    if (reply_load) begin
      kind_next   = 1'b0;
      status_next = rsp;
      slot_next   = rsp_slot;
      cell_next   = '0;
      last_next   = 1'b1;
    end else begin
      kind_next   = 1'b1;
      status_next = stb_pkg::RS_OK;
      slot_next   = pend_slot;
      cell_next   = pend_cell;
      last_next   = cmd.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind       <= kind_next;
      status     <= status_next;
      slot       <= slot_next;
      cell_value <= cell_next;
      last       <= last_next;
    end
  end

endmodule

// ===== rtl/software_timer_bank_core.sv =====
// Top level of the timeout timer bank: sequencer plus datapath.
// Depends on stb_pkg, stb_ctrl and stb_datapath.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------------------------
//   in      | in_valid/in_ready  | operation, timer_index, timeout_ticks, repeat_flag, soft_cell
//   out     | out_valid/out_ready| kind, status, slot, cell_value, last
//
// Open, close, stop, start and unsupported codes finish in the accept cycle;
// the reply sits in the output register from the next cycle.
// A tick runs through accept, a scan of every slot and a final flush; the slot
// record memory has one read port, so one slot per cycle unless stalled.
// Output backpressure stalls the scan only when a second expiry is found
// while the previous one still waits, and holds the flush until the output
// register frees up; in_ready is low throughout a tick.
// Synchronous reset closes every slot and clears the tick counter; no
// clearing pass is needed since a slot record only counts once it is opened.
module software_timer_bank_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [stb_pkg::OP_W-1:0]     operation,
  input  logic [stb_pkg::TIDX_W-1:0]   timer_index,
  input  logic [stb_pkg::TIME_W-1:0]   timeout_ticks,
  input  logic                         repeat_flag,
  input  logic [stb_pkg::CELL_W-1:0]   soft_cell,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         kind,
  output logic [stb_pkg::STAT_W-1:0]   status,
  output logic [stb_pkg::SLOT_W-1:0]   slot,
  output logic [stb_pkg::CELL_W-1:0]   cell_value,
  output logic                         last
);

  stb_pkg::ctl_cmd_t cmd;
  stb_pkg::dp_stat_t stat;

  // sequencer: owns the handshake on the input side
  stb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // datapath: slot state, record memory, output register
  stb_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .operation     (operation),
    .timer_index   (timer_index),
    .timeout_ticks (timeout_ticks),
    .repeat_flag   (repeat_flag),
    .soft_cell     (soft_cell),
    .out_ready     (out_ready),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .kind          (kind),
    .status        (status),
    .slot          (slot),
    .cell_value    (cell_value),
    .last          (last)
  );

`ifndef ASSERT_OFF
  // a non-tick item yields its reply in the next cycle
  a_reply_next: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && operation != stb_pkg::OP_TICK) |=>
      (out_valid && !kind && last))
    else $error("reply missing after accepted operation");

  // expiries always carry ok status
  a_expiry_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind) |-> (status == stb_pkg::RS_OK))
    else $error("expiry with nonzero status");

  // replies are always the only result of their item
  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !kind) |-> last)
    else $error("reply without last");

  // no item taken while a tick scan runs
  a_scan_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> !in_ready)
    else $error("input ready during tick scan");
`endif

endmodule
